>>> rtl/mail_body_content_scanner_macros.svh
// ----------------------------------------------------------------------------
// mail body content scanner assertion macros
// shared concurrent assertion forms for the scanner checks
// ----------------------------------------------------------------------------
`ifndef MAIL_BODY_CONTENT_SCANNER_MACROS_SVH
`define MAIL_BODY_CONTENT_SCANNER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msc check failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define MSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msc check failed: next-cycle implication");

`endif

>>> rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// types, character codes and defaults shared by the scanner modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msc_pkg;

	// defaults for top-level parameters
	localparam int unsigned COUNT_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// width of every reported total
	localparam int unsigned OUT_WIDTH = 32;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_M  = 8'h6D;
	localparam logic [7:0] CH_LO_O  = 8'h6F;
	localparam logic [7:0] CH_LO_R  = 8'h72;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// byte class, in decreasing priority
	typedef enum logic [2:0] {
		KIND_LF    = 3'd0,
		KIND_CR    = 3'd1,
		KIND_HIGH  = 3'd2,
		KIND_BLANK = 3'd3,
		KIND_NUL   = 3'd4,
		KIND_CTRL  = 3'd5,
		KIND_PRINT = 3'd6
	} byte_kind_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       eod;
		byte_kind_t kind;
		logic       is_tab;
		logic       is_space;
		logic       is_dot;
		logic       is_f;
		logic       is_r;
		logic       is_o;
		logic       is_m;
	} byte_class_t;

	// one finished result
	typedef struct packed {
		logic [OUT_WIDTH-1:0] printable_total;
		logic [OUT_WIDTH-1:0] high_bit_total;
		logic [OUT_WIDTH-1:0] control_total;
		logic [OUT_WIDTH-1:0] nul_total;
		logic [OUT_WIDTH-1:0] line_break_total;
		logic [OUT_WIDTH-1:0] longest_line;
		logic                 saw_binary;
		logic                 saw_cr;
		logic                 saw_trailing_blank;
		logic                 saw_lone_dot;
		logic                 saw_from_line;
	} scan_result_t;

endpackage

>>> rtl/msc_front.sv
// ----------------------------------------------------------------------------
// msc_front
// classifies each incoming byte into its kind and letter matches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msc_front (
	input  logic [7:0]          data_byte,
	input  logic                end_of_data,
	output msc_pkg::byte_class_t cls
);
	import msc_pkg::*;

	// kind by priority: lf, cr, high bit, blank, nul, control, printable
	always_comb begin
		cls          = '0;
		cls.eod      = end_of_data;
		cls.is_tab   = (data_byte == CH_TAB);
		cls.is_space = (data_byte == CH_SPACE);
		cls.is_dot   = (data_byte == CH_DOT);
		cls.is_f     = (data_byte == CH_UP_F) || (data_byte == CH_LO_F);
		cls.is_r     = (data_byte == CH_LO_R);
		cls.is_o     = (data_byte == CH_LO_O);
		cls.is_m     = (data_byte == CH_LO_M);
		if (data_byte == CH_LF) begin
			cls.kind = KIND_LF;
		end else if (data_byte == CH_CR) begin
			cls.kind = KIND_CR;
		end else if (data_byte[7]) begin
			cls.kind = KIND_HIGH;
		end else if (data_byte == CH_TAB || data_byte == CH_FF) begin
			cls.kind = KIND_BLANK;
		end else if (data_byte == CH_NUL) begin
			cls.kind = KIND_NUL;
		end else if (data_byte < CH_SPACE || data_byte == CH_DEL) begin
			cls.kind = KIND_CTRL;
		end else begin
			cls.kind = KIND_PRINT;
		end
	end

endmodule

>>> rtl/msc_fifo.sv
// ----------------------------------------------------------------------------
// msc_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msc_fifo #(
	parameter int unsigned DEPTH = msc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  msc_pkg::byte_class_t wr_data,
	output logic                 full,
	input  logic                 rd_en,
	output msc_pkg::byte_class_t rd_data,
	output logic                 empty
);
	import msc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	byte_class_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/msc_back.sv
// ----------------------------------------------------------------------------
// msc_back
// per-byte statistics update and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msc_back #(
	parameter int unsigned COUNT_WIDTH = msc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  msc_pkg::byte_class_t  head,
	output logic                  head_take,
	input  logic                  res_pop,
	output logic                  res_valid,
	output msc_pkg::scan_result_t res
);
	import msc_pkg::*;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	localparam cnt_t CNT_MAX = '1;

	// counters and line state
	cnt_t print_q, high_q, ctrl_q, nul_q, brk_q, max_q, len_q;
	cnt_t print_d, high_d, ctrl_d, nul_d, brk_d, max_d, len_d;
	logic after_cr_q, blank_q, dot_q, from_q;
	logic after_cr_d, blank_d, dot_d, from_d;
	// sticky flags
	logic fl_bin_q, fl_cr_q, fl_blank_q, fl_dot_q, fl_from_q;
	logic fl_bin_d, fl_cr_d, fl_blank_d, fl_dot_d, fl_from_d;

	cnt_t         len_inc;
	cnt_t         line_max;
	cnt_t         hold_max;
	logic         res_valid_q;
	scan_result_t res_q;
	scan_result_t res_d;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

	function automatic logic [OUT_WIDTH-1:0] clip_out(input cnt_t v);
		logic [63:0] w;
		w = 64'(v);
		return (|w[63:OUT_WIDTH]) ? '1 : w[OUT_WIDTH-1:0];
	endfunction

	// take the head unless it closes the stream while the last result waits
	assign head_take = head_valid && (!head.eod || !res_valid_q || res_pop);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign len_inc  = sat_inc(len_q);
	assign line_max = (len_inc > max_q) ? len_inc : max_q;
	assign hold_max = (len_q > max_q) ? len_q : max_q;

	// result fields at end of data
	always_comb begin
		res_d                    = '0;
		res_d.printable_total    = clip_out(print_q);
		res_d.high_bit_total     = clip_out(high_q);
		res_d.control_total      = clip_out(ctrl_q);
		res_d.nul_total          = clip_out(nul_q);
		res_d.line_break_total   = clip_out(brk_q);
		res_d.longest_line       = clip_out(hold_max);
		res_d.saw_binary         = fl_bin_q || after_cr_q;
		res_d.saw_cr             = fl_cr_q;
		res_d.saw_trailing_blank = fl_blank_q;
		res_d.saw_lone_dot       = fl_dot_q;
		res_d.saw_from_line      = fl_from_q;
	end

	// next state for one item
	always_comb begin
		print_d    = print_q;
		high_d     = high_q;
		ctrl_d     = ctrl_q;
		nul_d      = nul_q;
		brk_d      = brk_q;
		max_d      = max_q;
		len_d      = len_q;
		after_cr_d = after_cr_q;
		blank_d    = blank_q;
		dot_d      = dot_q;
		from_d     = from_q;
		fl_bin_d   = fl_bin_q;
		fl_cr_d    = fl_cr_q;
		fl_blank_d = fl_blank_q;
		fl_dot_d   = fl_dot_q;
		fl_from_d  = fl_from_q;
		if (head.eod) begin
			// stream closed: everything back to reset values
			print_d    = '0;
			high_d     = '0;
			ctrl_d     = '0;
			nul_d      = '0;
			brk_d      = '0;
			max_d      = '0;
			len_d      = '0;
			after_cr_d = 1'b0;
			blank_d    = 1'b0;
			dot_d      = 1'b0;
			from_d     = 1'b0;
			fl_bin_d   = 1'b0;
			fl_cr_d    = 1'b0;
			fl_blank_d = 1'b0;
			fl_dot_d   = 1'b0;
			fl_from_d  = 1'b0;
		end else if (after_cr_q && head.kind == KIND_LF) begin
			// lf completing a crlf ends the line without counting
			fl_blank_d = fl_blank_q || blank_q;
			fl_dot_d   = fl_dot_q || dot_q;
			max_d      = hold_max;
			len_d      = '0;
			blank_d    = 1'b0;
			dot_d      = 1'b0;
			after_cr_d = 1'b0;
		end else begin
			// cr not followed by lf marks the body as binary
			if (after_cr_q) begin
				fl_bin_d = 1'b1;
			end
			after_cr_d = 1'b0;
			len_d      = len_inc;
			dot_d      = (len_q != '0) ? 1'b0 : dot_q;
			blank_d    = 1'b0;
			unique case (head.kind)
				KIND_LF: begin
					brk_d      = sat_inc(brk_q);
					fl_blank_d = fl_blank_q || blank_q;
					fl_dot_d   = fl_dot_q || dot_q;
					max_d      = line_max;
					len_d      = '0;
					dot_d      = 1'b0;
				end
				KIND_CR: begin
					brk_d      = sat_inc(brk_q);
					fl_cr_d    = 1'b1;
					after_cr_d = 1'b1;
					blank_d    = blank_q;
					dot_d      = dot_q;
				end
				KIND_HIGH: begin
					high_d = sat_inc(high_q);
				end
				KIND_BLANK: begin
					// tab leaves a blank pending, form feed does not
					print_d = sat_inc(print_q);
					blank_d = head.is_tab;
				end
				KIND_NUL: begin
					nul_d  = sat_inc(nul_q);
					ctrl_d = sat_inc(ctrl_q);
				end
				KIND_CTRL: begin
					ctrl_d = sat_inc(ctrl_q);
				end
				KIND_PRINT: begin
					print_d = sat_inc(print_q);
					blank_d = head.is_space;
					if (len_q == '0) begin
						from_d = head.is_f;
						dot_d  = head.is_dot;
					end else if (from_q) begin
						// match "rom" at line positions two to four
						if (len_q == cnt_t'(1)) begin
							from_d = head.is_r;
						end else if (len_q == cnt_t'(2)) begin
							from_d = head.is_o;
						end else if (len_q == cnt_t'(3)) begin
							fl_from_d = fl_from_q || head.is_m;
							from_d    = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			print_q    <= '0;
			high_q     <= '0;
			ctrl_q     <= '0;
			nul_q      <= '0;
			brk_q      <= '0;
			max_q      <= '0;
			len_q      <= '0;
			after_cr_q <= 1'b0;
			blank_q    <= 1'b0;
			dot_q      <= 1'b0;
			from_q     <= 1'b0;
			fl_bin_q   <= 1'b0;
			fl_cr_q    <= 1'b0;
			fl_blank_q <= 1'b0;
			fl_dot_q   <= 1'b0;
			fl_from_q  <= 1'b0;
		end else if (head_take) begin
			print_q    <= print_d;
			high_q     <= high_d;
			ctrl_q     <= ctrl_d;
			nul_q      <= nul_d;
			brk_q      <= brk_d;
			max_q      <= max_d;
			len_q      <= len_d;
			after_cr_q <= after_cr_d;
			blank_q    <= blank_d;
			dot_q      <= dot_d;
			from_q     <= from_d;
			fl_bin_q   <= fl_bin_d;
			fl_cr_q    <= fl_cr_d;
			fl_blank_q <= fl_blank_d;
			fl_dot_q   <= fl_dot_d;
			fl_from_q  <= fl_from_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (head_take && head.eod) begin
			res_valid_q <= 1'b1;
		end else if (res_pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (head_take && head.eod) begin
			res_q <= res_d;
		end
	end

endmodule

>>> rtl/mail_body_content_scanner.sv
// ----------------------------------------------------------------------------
// mail_body_content_scanner
// byte-wise mail body statistics for transfer encoding choice
// ----------------------------------------------------------------------------
// Input side is a queue: drive data_byte / end_of_data with push while full is
// low; one item is taken per such edge. An item with end_of_data closes the
// stream and yields one result; every other item yields none.
// Result side is a queue: while empty is low the result is on the ports and
// pop takes it.
// Throughput: one item per cycle while no waiting result stalls the back end,
// set by the per-item update in the back end. A closing item passes the item
// queue and then the result register before its result shows on the ports.
// A QUEUE_DEPTH-entry item queue (four by default) sits between classifier
// and statistics unit; a single result register follows the statistics unit.
// A waiting result stalls the back end only when the next closing item
// reaches it; bytes keep flowing until then, and the queue then fills and
// raises full.
// Reset clears queue, counters, flags and result valid; empty is high and
// full is low after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mail_body_content_scanner #(
	parameter int unsigned COUNT_WIDTH = msc_pkg::COUNT_WIDTH_DEF,
	parameter int unsigned QUEUE_DEPTH = msc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_data,
	output logic                          empty,
	input  logic                          pop,
	output logic [msc_pkg::OUT_WIDTH-1:0] printable_total,
	output logic [msc_pkg::OUT_WIDTH-1:0] high_bit_total,
	output logic [msc_pkg::OUT_WIDTH-1:0] control_total,
	output logic [msc_pkg::OUT_WIDTH-1:0] nul_total,
	output logic [msc_pkg::OUT_WIDTH-1:0] line_break_total,
	output logic [msc_pkg::OUT_WIDTH-1:0] longest_line,
	output logic                          saw_binary,
	output logic                          saw_cr,
	output logic                          saw_trailing_blank,
	output logic                          saw_lone_dot,
	output logic                          saw_from_line
);
	import msc_pkg::*;

	byte_class_t  in_cls;
	byte_class_t  head_cls;
	logic         q_full;
	logic         q_empty;
	logic         head_take;
	logic         res_valid;
	scan_result_t res;

	// front: classify incoming bytes
	msc_front u_front (
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.cls         (in_cls)
	);

	// item queue between front and back
	msc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !q_full),
		.wr_data (in_cls),
		.full    (q_full),
		.rd_en   (head_take),
		.rd_data (head_cls),
		.empty   (q_empty)
	);

	// back: statistics and result register
	msc_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (head_cls),
		.head_take  (head_take),
		.res_pop    (pop && res_valid),
		.res_valid  (res_valid),
		.res        (res)
	);

	// queue-style handshakes and result fields
	assign full               = q_full;
	assign empty              = !res_valid;
	assign printable_total    = res.printable_total;
	assign high_bit_total     = res.high_bit_total;
	assign control_total      = res.control_total;
	assign nul_total          = res.nul_total;
	assign line_break_total   = res.line_break_total;
	assign longest_line       = res.longest_line;
	assign saw_binary         = res.saw_binary;
	assign saw_cr             = res.saw_cr;
	assign saw_trailing_blank = res.saw_trailing_blank;
	assign saw_lone_dot       = res.saw_lone_dot;
	assign saw_from_line      = res.saw_from_line;

endmodule

>>> rtl/msc_checker.sv
// ----------------------------------------------------------------------------
// msc_checker
// port-level checks on the scanner result channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mail_body_content_scanner_macros.svh"

module msc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [msc_pkg::OUT_WIDTH-1:0] printable_total,
	input logic [msc_pkg::OUT_WIDTH-1:0] line_break_total,
	input logic [msc_pkg::OUT_WIDTH-1:0] longest_line,
	input logic                          saw_binary,
	input logic                          saw_cr,
	input logic                          saw_from_line
);
	import msc_pkg::*;

	// a waiting result stays put until taken
	`MSC_ASSERT_NEXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(longest_line) && $stable(line_break_total))

	// binary only arises from a carriage return
	`MSC_ASSERT_IMPLY(a_bin_needs_cr, clk, arst_n, !empty && saw_binary, saw_cr)

	// every carriage return is counted as a line break
	`MSC_ASSERT_IMPLY(a_cr_counted, clk, arst_n, !empty && saw_cr, line_break_total != '0)

	// a from line takes four printable bytes
	`MSC_ASSERT_IMPLY(a_from_printable, clk, arst_n, !empty && saw_from_line, printable_total >= OUT_WIDTH'(4))

endmodule

bind mail_body_content_scanner msc_checker u_msc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.empty            (empty),
	.pop              (pop),
	.printable_total  (printable_total),
	.line_break_total (line_break_total),
	.longest_line     (longest_line),
	.saw_binary       (saw_binary),
	.saw_cr           (saw_cr),
	.saw_from_line    (saw_from_line)
);

>>> sim/mail_body_content_scanner_checker.sv
// ----------------------------------------------------------------------------
// mail_body_content_scanner_checker
// watches both queue sides of the scanner, predicts every report and compares
// ----------------------------------------------------------------------------
// Each byte taken on the input side updates a private copy of the scan state.
// A closing item turns that state into an expected report. Each report taken
// on the output side is compared field by field with the oldest expectation.
// The mismatch count and the number of reports still owed go to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mail_body_content_scanner_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_data,
	input  logic                          empty,
	input  logic                          pop,
	input  logic [msc_pkg::OUT_WIDTH-1:0] printable_total,
	input  logic [msc_pkg::OUT_WIDTH-1:0] high_bit_total,
	input  logic [msc_pkg::OUT_WIDTH-1:0] control_total,
	input  logic [msc_pkg::OUT_WIDTH-1:0] nul_total,
	input  logic [msc_pkg::OUT_WIDTH-1:0] line_break_total,
	input  logic [msc_pkg::OUT_WIDTH-1:0] longest_line,
	input  logic                          saw_binary,
	input  logic                          saw_cr,
	input  logic                          saw_trailing_blank,
	input  logic                          saw_lone_dot,
	input  logic                          saw_from_line,
	output int                            errors,
	output int                            outstanding
);

	import msc_pkg::*;

	localparam int unsigned CW = COUNT_WIDTH_DEF;
	localparam logic [63:0] COUNT_CEIL = (CW >= 64) ? '1 : ((64'd1 << CW) - 64'd1);
	localparam logic [63:0] OUT_CEIL = (64'd1 << OUT_WIDTH) - 64'd1;

	// predicted scan state
	logic        cr_open;
	logic        from_armed;
	logic        blank_tail;
	logic        dot_line;
	logic [63:0] line_len;
	logic [63:0] n_print;
	logic [63:0] n_high;
	logic [63:0] n_ctrl;
	logic [63:0] n_nul;
	logic [63:0] n_break;
	logic [63:0] max_len;
	logic        seen_binary;
	logic        seen_cr;
	logic        seen_blank;
	logic        seen_dot;
	logic        seen_from;

	scan_result_t expected_reports[$];
	int           miss_total;

	// saturating count step
	function automatic logic [63:0] bump(input logic [63:0] v);
		return (v >= COUNT_CEIL) ? COUNT_CEIL : v + 64'd1;
	endfunction

	// report width clip
	function automatic logic [OUT_WIDTH-1:0] clip(input logic [63:0] v);
		return (v > OUT_CEIL) ? '1 : v[OUT_WIDTH-1:0];
	endfunction

	task automatic clear_scan();
		cr_open     = 1'b0;
		from_armed  = 1'b0;
		blank_tail  = 1'b0;
		dot_line    = 1'b0;
		line_len    = '0;
		n_print     = '0;
		n_high      = '0;
		n_ctrl      = '0;
		n_nul       = '0;
		n_break     = '0;
		max_len     = '0;
		seen_binary = 1'b0;
		seen_cr     = 1'b0;
		seen_blank  = 1'b0;
		seen_dot    = 1'b0;
		seen_from   = 1'b0;
	endtask

	// a line break closes the current line
	task automatic close_line();
		if (blank_tail)
			seen_blank = 1'b1;
		if (dot_line)
			seen_dot = 1'b1;
		if (line_len > max_len)
			max_len = line_len;
		blank_tail = 1'b0;
		dot_line   = 1'b0;
		line_len   = '0;
	endtask

	// one body byte
	task automatic scan_byte(input logic [7:0] b);
		if (cr_open) begin
			cr_open = 1'b0;
			if (b == CH_LF) begin
				close_line();
				return;
			end
			seen_binary = 1'b1;
		end
		line_len = bump(line_len);
		if (b == CH_LF) begin
			n_break = bump(n_break);
			close_line();
		end else if (b == CH_CR) begin
			n_break = bump(n_break);
			seen_cr = 1'b1;
			cr_open = 1'b1;
			return;
		end else if (b[7]) begin
			n_high = bump(n_high);
		end else if (b == CH_TAB || b == CH_FF) begin
			n_print    = bump(n_print);
			blank_tail = 1'b1;
		end else if (b == CH_NUL) begin
			n_nul  = bump(n_nul);
			n_ctrl = bump(n_ctrl);
		end else if (b < CH_SPACE || b == CH_DEL) begin
			n_ctrl = bump(n_ctrl);
		end else begin
			// from check runs on byte positions, dot check on the first byte only
			if (line_len == 64'd1) begin
				from_armed = (b == CH_UP_F || b == CH_LO_F);
				dot_line   = (b == CH_DOT);
			end else if (from_armed) begin
				if (line_len == 64'd2 && b != CH_LO_R) begin
					from_armed = 1'b0;
				end else if (line_len == 64'd3 && b != CH_LO_O) begin
					from_armed = 1'b0;
				end else if (line_len == 64'd4) begin
					if (b == CH_LO_M)
						seen_from = 1'b1;
					from_armed = 1'b0;
				end
			end
			if (b == CH_SPACE)
				blank_tail = 1'b1;
			n_print = bump(n_print);
		end
		if (line_len > 64'd1)
			dot_line = 1'b0;
		if (b != CH_SPACE && b != CH_TAB)
			blank_tail = 1'b0;
	endtask

	// closing item: build the report, then start over
	task automatic close_stream();
		scan_result_t r;
		if (cr_open)
			seen_binary = 1'b1;
		if (line_len > max_len)
			max_len = line_len;
		r.printable_total    = clip(n_print);
		r.high_bit_total     = clip(n_high);
		r.control_total      = clip(n_ctrl);
		r.nul_total          = clip(n_nul);
		r.line_break_total   = clip(n_break);
		r.longest_line       = clip(max_len);
		r.saw_binary         = seen_binary;
		r.saw_cr             = seen_cr;
		r.saw_trailing_blank = seen_blank;
		r.saw_lone_dot       = seen_dot;
		r.saw_from_line      = seen_from;
		expected_reports.push_back(r);
		clear_scan();
	endtask

	function automatic int check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// report side first, then input side
	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			clear_scan();
			expected_reports.delete();
			miss_total = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_reports.size() == 0) begin
					$display("%0t ns: unexpected report, expected none actual printable %0h",
						$time, printable_total);
					miss_total++;
				end else begin
					want = expected_reports.pop_front();
					miss_total += check_field("printable_total",
						64'(want.printable_total), 64'(printable_total));
					miss_total += check_field("high_bit_total",
						64'(want.high_bit_total), 64'(high_bit_total));
					miss_total += check_field("control_total",
						64'(want.control_total), 64'(control_total));
					miss_total += check_field("nul_total",
						64'(want.nul_total), 64'(nul_total));
					miss_total += check_field("line_break_total",
						64'(want.line_break_total), 64'(line_break_total));
					miss_total += check_field("longest_line",
						64'(want.longest_line), 64'(longest_line));
					miss_total += check_field("saw_binary",
						64'(want.saw_binary), 64'(saw_binary));
					miss_total += check_field("saw_cr",
						64'(want.saw_cr), 64'(saw_cr));
					miss_total += check_field("saw_trailing_blank",
						64'(want.saw_trailing_blank), 64'(saw_trailing_blank));
					miss_total += check_field("saw_lone_dot",
						64'(want.saw_lone_dot), 64'(saw_lone_dot));
					miss_total += check_field("saw_from_line",
						64'(want.saw_from_line), 64'(saw_from_line));
				end
			end
			if (push && !full) begin
				if (end_of_data)
					close_stream();
				else
					scan_byte(data_byte);
			end
			errors      <= miss_total;
			outstanding <= expected_reports.size();
		end
	end

endmodule

>>> sim/mail_body_content_scanner_tb.sv
// ----------------------------------------------------------------------------
// mail_body_content_scanner_tb
// stimulus and verdict for the mail body content scanner
// ----------------------------------------------------------------------------
// A short directed stream set covers the empty stream, byte class extremes,
// from lines, lone dots, trailing blanks and every way a CR can end. Then
// random mail bodies built from lines of several shapes plus raw noise are
// pushed in bursts with gaps while the report side stalls on its own pattern.
// The checker beside the block predicts and compares; a watchdog ends a hang.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mail_body_content_scanner_tb;

	import msc_pkg::*;

	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [7:0]           data_byte;
	logic                 end_of_data;
	logic                 empty;
	logic                 pop;
	logic [OUT_WIDTH-1:0] printable_total;
	logic [OUT_WIDTH-1:0] high_bit_total;
	logic [OUT_WIDTH-1:0] control_total;
	logic [OUT_WIDTH-1:0] nul_total;
	logic [OUT_WIDTH-1:0] line_break_total;
	logic [OUT_WIDTH-1:0] longest_line;
	logic                 saw_binary;
	logic                 saw_cr;
	logic                 saw_trailing_blank;
	logic                 saw_lone_dot;
	logic                 saw_from_line;

	int errors;
	int outstanding;
	int items_sent;
	int burst_left;
	int idle_cycles;

	mail_body_content_scanner DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.data_byte          (data_byte),
		.end_of_data        (end_of_data),
		.empty              (empty),
		.pop                (pop),
		.printable_total    (printable_total),
		.high_bit_total     (high_bit_total),
		.control_total      (control_total),
		.nul_total          (nul_total),
		.line_break_total   (line_break_total),
		.longest_line       (longest_line),
		.saw_binary         (saw_binary),
		.saw_cr             (saw_cr),
		.saw_trailing_blank (saw_trailing_blank),
		.saw_lone_dot       (saw_lone_dot),
		.saw_from_line      (saw_from_line)
	);

	mail_body_content_scanner_checker u_stats_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.data_byte          (data_byte),
		.end_of_data        (end_of_data),
		.empty              (empty),
		.pop                (pop),
		.printable_total    (printable_total),
		.high_bit_total     (high_bit_total),
		.control_total      (control_total),
		.nul_total          (nul_total),
		.line_break_total   (line_break_total),
		.longest_line       (longest_line),
		.saw_binary         (saw_binary),
		.saw_cr             (saw_cr),
		.saw_trailing_blank (saw_trailing_blank),
		.saw_lone_dot       (saw_lone_dot),
		.saw_from_line      (saw_from_line),
		.errors             (errors),
		.outstanding        (outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// report side stalls: calm runs, long holds and coin flips
	initial begin
		int hold_left;
		int calm_left;
		hold_left = 0;
		calm_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop = 1'b0;
				hold_left--;
			end else if (calm_left > 0) begin
				pop = 1'b1;
				calm_left--;
			end else begin
				case ($urandom_range(0, 3))
					0: calm_left = $urandom_range(20, 80);
					1: hold_left = $urandom_range(1, 40);
					default: pop = 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// one item, held until taken; bursts broken by random gaps
	task automatic send_item(input logic [7:0] b, input logic e);
		if (burst_left <= 0) begin
			push = 1'b0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
		end
		push        = 1'b1;
		data_byte   = b;
		end_of_data = e;
		@(posedge clk);
		while (full)
			@(posedge clk);
		burst_left--;
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input int n);
		repeat (n) send_item(8'($urandom_range(32, 126)), 1'b0);
	endtask

	// mostly the wanted letter, sometimes something that may break the match
	function automatic logic [7:0] maybe_spoil(input logic [7:0] c);
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(1, 31));
			1: return 8'($urandom_range(32, 126));
			2: return 8'($urandom_range(128, 255));
			default: return c;
		endcase
	endfunction

	// one random line of some shape and its ending
	task automatic send_line();
		int blanks;
		case ($urandom_range(0, 9))
			0, 1: begin
				send_item(($urandom_range(0, 1) != 0) ? CH_UP_F : CH_LO_F, 1'b0);
				send_item(maybe_spoil(CH_LO_R), 1'b0);
				send_item(maybe_spoil(CH_LO_O), 1'b0);
				send_item(maybe_spoil(CH_LO_M), 1'b0);
				send_text($urandom_range(0, 6));
			end
			2: send_item(CH_DOT, 1'b0);
			3: begin
				send_text($urandom_range(0, 8));
				blanks = $urandom_range(1, 3);
				repeat (blanks) begin
					case ($urandom_range(0, 2))
						0: send_item(CH_SPACE, 1'b0);
						1: send_item(CH_TAB, 1'b0);
						default: send_item(CH_FF, 1'b0);
					endcase
				end
			end
			4: repeat ($urandom_range(1, 10)) send_item(8'($urandom_range(0, 255)), 1'b0);
			default: begin
				if ($urandom_range(0, 19) == 0)
					send_text($urandom_range(40, 250));
				else
					send_text($urandom_range(0, 12));
			end
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3: send_item(CH_LF, 1'b0);
			4, 5, 6: begin
				send_item(CH_CR, 1'b0);
				send_item(CH_LF, 1'b0);
			end
			7: send_item(CH_CR, 1'b0);
			8: begin
				send_item(CH_CR, 1'b0);
				send_item(CH_CR, 1'b0);
			end
			default: ;
		endcase
	endtask

	initial begin
		push        = 1'b0;
		data_byte   = 8'h00;
		end_of_data = 1'b0;
		items_sent  = 0;
		burst_left  = 0;
		arst_n      = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// empty stream
		send_item(8'hFF, 1'b1);

		// from line ending in space and tab
		send_item(CH_UP_F, 1'b0);
		send_item(CH_LO_R, 1'b0);
		send_item(CH_LO_O, 1'b0);
		send_item(CH_LO_M, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_item(CH_LF, 1'b0);
		// lone dot closed by crlf
		send_item(CH_DOT, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(CH_LF, 1'b0);
		// byte class extremes, line ending in form feed
		send_item(CH_NUL, 1'b0);
		send_item(CH_DEL, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_FF, 1'b0);
		send_item(CH_LF, 1'b0);
		// bare cr inside a line
		send_item(CH_CR, 1'b0);
		send_item(CH_LO_M, 1'b0);
		// from candidate carried into a line that opens with a control byte
		send_item(CH_LO_F, 1'b0);
		send_item(CH_LF, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(CH_LO_R, 1'b0);
		send_item(CH_LO_O, 1'b0);
		send_item(CH_LO_M, 1'b0);
		// cr as last byte of the stream
		send_item(CH_CR, 1'b0);
		send_item(8'h00, 1'b1);

		// random bodies
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			repeat ($urandom_range(1, 5)) send_line();
			if ($urandom_range(0, 7) == 0)
				send_item(CH_CR, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end
		push = 1'b0;

		// drain
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
